FILE: src/pat_pkg.sv
package pat_pkg;

  // ring geometry
  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  // payload widths
  localparam int STAMP_W = 16;
  localparam int SPEED_W = 16;
  localparam int DIVR_W  = 8;
  localparam int CNT_W   = 2;

  // running sum of the ring and the divider word (sum scaled by 8)
  localparam int SUM_W = STAMP_W + $clog2(RING_DEPTH);
  localparam int DIV_W = SUM_W + 3;

  // constants of the speed formula and the period filter
  localparam int SPEED_NUM    = 950000;
  localparam int MIN_PERIOD   = 300;
  localparam int STALL_RELOAD = 2;
  localparam logic [STAMP_W-1:0] BAD_PERIOD = {STAMP_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX  = {SPEED_W{1'b1}};

  // input op codes
  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/pat_capture_if.sv
interface pat_capture_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [pat_pkg::STAMP_W-1:0] capture_time;

  modport source (output valid, output op, output capture_time, input ready);
  modport sink (input valid, input op, input capture_time, output ready);
endinterface

FILE: src/pat_result_if.sv
interface pat_result_if;
  logic                        valid;
  logic                        ready;
  logic [pat_pkg::SPEED_W-1:0] speed;
  logic                        stalled;

  modport source (output valid, output speed, output stalled, input ready);
  modport sink (input valid, input speed, input stalled, output ready);
endinterface

FILE: src/pat_ram.sv
module pat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pat_div.sv
module pat_div (
  input  logic              clk,
  input  logic              rst,
  input  pat_pkg::div_req_t req,
  output pat_pkg::div_rsp_t rsp
);

  localparam int W     = pat_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [W-1:0]     rem;
  logic [W-1:0]     num;
  logic [W-1:0]     dvsr;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       qbit;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem, num[W-1]};
    diff  = trial - {1'b0, dvsr};
    qbit  = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(W);
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= qbit ? diff[W-1:0] : trial[W-1:0];
      num <= {num[W-2:0], qbit};
    end else if (req.start) begin
      rem  <= '0;
      num  <= req.dividend;
      dvsr <= req.divisor;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

FILE: src/period_averaging_tachometer.sv
// Period-averaging tachometer: one item (capture or overflow tick) at a time.
// An item's result is set by up to two passes of the shared one-bit-per-cycle
// divider; a stalled item skips the divider and goes straight to the result.
// The next item is taken while the result waits in the output register.
// Reset (rst, synchronous): ring reads as zero via valid bits, index at top.
module period_averaging_tachometer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pat_pkg::DIVR_W-1:0] cfg_wr_data,
  pat_capture_if.sink                capture,
  pat_result_if.source               result
);

  localparam int IDX_W = pat_pkg::IDX_W;
  localparam int SUM_W = pat_pkg::SUM_W;
  localparam int DIV_W = pat_pkg::DIV_W;
  localparam int SW    = pat_pkg::STAMP_W;
  localparam int CW    = pat_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_CALC = 6'b000100,
    S_DIV1 = 6'b001000,
    S_DIV2 = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [pat_pkg::DIVR_W-1:0] speed_divisor;
  logic [IDX_W-1:0]           ring_index;
  logic [SW-1:0]              last_stamp;
  logic [CW-1:0]              stall_countdown;
  logic [SUM_W-1:0]           sum;
  logic [pat_pkg::RING_DEPTH-1:0] entry_valid;
  logic [SW-1:0]              period;
  logic [pat_pkg::SPEED_W-1:0] res_speed;
  logic                       res_stalled;

  logic                        out_valid;
  logic [pat_pkg::SPEED_W-1:0] out_speed;
  logic                        out_stalled;

  logic             accept;
  logic [SW-1:0]    diff;
  logic             bad;
  logic [SW-1:0]    period_new;
  logic [SW-1:0]    ram_rdata;
  logic [SW-1:0]    old_entry;
  logic             out_free;

  pat_pkg::div_req_t div_req;
  pat_pkg::div_rsp_t div_rsp;

  assign capture.ready = (state == S_IDLE);
  assign accept        = capture.valid & capture.ready;
  assign out_free      = ~out_valid | result.ready;

  // period filter for a capture
  always_comb begin
    diff = capture.capture_time - last_stamp;
    bad  = (stall_countdown == '0) ||
           ((stall_countdown == CW'(1)) && (capture.capture_time >= last_stamp));
    if (bad || (diff < SW'(pat_pkg::MIN_PERIOD))) begin
      period_new = pat_pkg::BAD_PERIOD;
    end else begin
      period_new = diff;
    end
  end

  // ring storage; old entry is read at accept, replaced in S_UPD
  pat_ram #(
    .WIDTH(SW),
    .DEPTH(pat_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (state == S_UPD),
    .waddr(ring_index),
    .wdata(period),
    .re   (accept),
    .raddr(ring_index),
    .rdata(ram_rdata)
  );

  assign old_entry = entry_valid[ring_index] ? ram_rdata : '0;

  pat_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // divider requests
  always_comb begin
    div_req = '0;
    if (state == S_CALC && stall_countdown != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = {sum, 3'b000};
      div_req.divisor  = (speed_divisor == '0) ? DIV_W'(1) : DIV_W'(speed_divisor);
    end else if (state == S_DIV1 && div_rsp.done && div_rsp.quotient != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(pat_pkg::SPEED_NUM);
      div_req.divisor  = div_rsp.quotient;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_divisor <= pat_pkg::DIVR_W'(1);
    end else if (cfg_wr_en) begin
      speed_divisor <= cfg_wr_data;
    end
  end

  // output register: loaded from S_DONE, cleared when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid   <= 1'b1;
      out_speed   <= res_speed;
      out_stalled <= res_stalled;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ring_index      <= IDX_W'(pat_pkg::RING_DEPTH - 1);
      last_stamp      <= '0;
      stall_countdown <= '0;
      sum             <= '0;
      entry_valid     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (capture.op == pat_pkg::OP_CAPTURE) begin
              period          <= period_new;
              stall_countdown <= CW'(pat_pkg::STALL_RELOAD);
              if (!bad) begin
                last_stamp <= capture.capture_time;
              end
              state <= S_UPD;
            end else begin
              if (stall_countdown != '0) begin
                stall_countdown <= stall_countdown - CW'(1);
              end
              state <= S_CALC;
            end
          end
        end
        S_UPD: begin
          sum                     <= sum - SUM_W'(old_entry) + SUM_W'(period);
          entry_valid[ring_index] <= 1'b1;
          if (ring_index == '0) begin
            ring_index <= IDX_W'(pat_pkg::RING_DEPTH - 1);
          end else begin
            ring_index <= ring_index - IDX_W'(1);
          end
          state <= S_CALC;
        end
        S_CALC: begin
          if (stall_countdown == '0) begin
            res_speed   <= '0;
            res_stalled <= 1'b1;
            state       <= S_DONE;
          end else begin
            res_stalled <= 1'b0;
            state       <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              res_speed <= pat_pkg::SPEED_MAX;
              state     <= S_DONE;
            end else begin
              state <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[DIV_W-1:pat_pkg::SPEED_W] != '0) begin
              res_speed <= pat_pkg::SPEED_MAX;
            end else begin
              res_speed <= div_rsp.quotient[pat_pkg::SPEED_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid   = out_valid;
  assign result.speed   = out_speed;
  assign result.stalled = out_stalled;

endmodule
